// ===== rtl/tvbc_pkg.sv =====
package tvbc_pkg;

   // Register indexes on the configuration port
   localparam logic [2:0] CSR_KEY0  = 3'd0;
   localparam logic [2:0] CSR_KEY1  = 3'd1;
   localparam logic [2:0] CSR_KEY2  = 3'd2;
   localparam logic [2:0] CSR_KEY3  = 3'd3;
   localparam logic [2:0] CSR_DELTA = 3'd4;

   // Request kinds carried on tuser
   localparam logic REQ_ENCRYPT = 1'b0;
   localparam logic REQ_DECRYPT = 1'b1;

   // Register reset values
   localparam logic [31:0] KEY0_RESET  = 32'h423D_F72D;
   localparam logic [31:0] KEY1_RESET  = 32'h05F5_9A01;
   localparam logic [31:0] KEY2_RESET  = 32'h633F_CF1D;
   localparam logic [31:0] KEY3_RESET  = 32'h77D1_9122;
   localparam logic [31:0] DELTA_RESET = 32'h5E23_77FF;

   // Whitening mask applied to both words
   localparam logic [31:0] WHITEN_MASK = 32'h0000_000F;

   // Key schedule shared by every round stage
   typedef struct packed {
      logic [31:0] key0;
      logic [31:0] key1;
      logic [31:0] key2;
      logic [31:0] key3;
      logic [31:0] delta;
   } keys_type;

   // Block state travelling down the pipeline
   typedef struct packed {
      logic        decrypt;
      logic [31:0] word_a;
      logic [31:0] word_b;
      logic [31:0] sum;
   } lane_type;

   // TEA mixing function: three parallel adds folded by XOR
   function automatic logic [31:0] mix(input logic [31:0] x, input logic [31:0] ka,
                                       input logic [31:0] kb, input logic [31:0] s);
      logic [31:0] left_term;
      logic [31:0] mid_term;
      logic [31:0] right_term;
      left_term  = {x[27:0], 4'b0000} + ka;
      mid_term   = x + s;
      right_term = {5'b00000, x[31:5]} + kb;
      return left_term ^ mid_term ^ right_term;
   endfunction

endpackage

// ===== rtl/tvbc_round_stage.sv =====
module tvbc_round_stage #(
   parameter logic SECOND_HALF = 1'b0
) (
   input  logic               clock,
   input  logic               reset,
   input  tvbc_pkg::keys_type keys,
   input  logic               in_valid,
   output logic               in_ready,
   input  tvbc_pkg::lane_type in_lane,
   output logic               out_valid,
   input  logic               out_ready,
   output tvbc_pkg::lane_type out_lane
);
   import tvbc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   lane_type lane_ff;
   lane_type lane_in;
   logic [31:0] mix_val;

   // Take a new item whenever this stage is empty or drains this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // One half-round: first word from the second, or second from the first
   always_comb begin
      lane_in = in_lane;
      mix_val = '0;
      if (!SECOND_HALF) begin
         if (in_lane.decrypt == REQ_DECRYPT) begin
            mix_val        = mix(in_lane.word_a, keys.key2, keys.key3, in_lane.sum);
            lane_in.word_b = in_lane.word_b - mix_val;
         end else begin
            mix_val        = mix(in_lane.word_b, keys.key0, keys.key1, in_lane.sum);
            lane_in.word_a = in_lane.word_a + mix_val;
         end
      end else begin
         if (in_lane.decrypt == REQ_DECRYPT) begin
            mix_val        = mix(in_lane.word_b, keys.key0, keys.key1, in_lane.sum);
            lane_in.word_a = in_lane.word_a - mix_val;
            lane_in.sum    = in_lane.sum - keys.delta;
         end else begin
            mix_val        = mix(in_lane.word_a, keys.key2, keys.key3, in_lane.sum);
            lane_in.word_b = in_lane.word_b + mix_val;
            lane_in.sum    = in_lane.sum + keys.delta;
         end
      end
   end

   // Hold valid under reset
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Advance payload only on an accepted item
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         lane_ff <= lane_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_lane  = lane_ff;

endmodule

// ===== rtl/tea_variant_block_cipher_unit.sv =====
// Channel  Ports                       Payload
// -------  --------------------------  -----------------------------------------
// request  req_tvalid/tready/tdata/    tdata: word_first, word_second; tuser:
//          tuser                       req_type (0 encrypt, 1 decrypt)
// result   rsp_tvalid/tready/tdata     tdata: result_first, result_second
// config   csr_we/index/wdata          key words 0..3 at 0..3, round delta at 4
//
// One entry stage does whitening and the start sum, then one register stage per
// half-round. One block is accepted per cycle while the pipeline is not full.
// Reset empties every stage and loads the default key and delta.
// Each stage holds its item while the stage after it is full and stalled; an
// empty stage still takes a new item, so bubbles close up under back-pressure.
module tea_variant_block_cipher_unit #(
   parameter int ROUNDS = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] word_first, [63:32] word_second
   input  logic        req_tuser,   // [0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [31:0] result_first, [63:32] result_second
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tvbc_pkg::*;

   localparam int STAGES = 2 * ROUNDS;

   keys_type keys_ff;
   logic     entry_valid_ff;
   logic     entry_valid_in;
   logic     entry_ready;
   lane_type entry_lane_ff;
   lane_type entry_lane_in;
   logic [31:0] total_sum;

   logic     stage_valid [STAGES+1];
   logic     stage_ready [STAGES+1];
   lane_type stage_lane  [STAGES+1];
   lane_type last_lane;

   // Write configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         keys_ff.key0  <= KEY0_RESET;
         keys_ff.key1  <= KEY1_RESET;
         keys_ff.key2  <= KEY2_RESET;
         keys_ff.key3  <= KEY3_RESET;
         keys_ff.delta <= DELTA_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY0:  keys_ff.key0  <= csr_wdata;
            CSR_KEY1:  keys_ff.key1  <= csr_wdata;
            CSR_KEY2:  keys_ff.key2  <= csr_wdata;
            CSR_KEY3:  keys_ff.key3  <= csr_wdata;
            CSR_DELTA: keys_ff.delta <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Entry stage: whiten on decrypt and pick the starting sum
   assign total_sum = keys_ff.delta * 32'(ROUNDS);

   always_comb begin
      entry_lane_in.decrypt = req_tuser;
      if (req_tuser == REQ_DECRYPT) begin
         entry_lane_in.word_a = req_tdata[31:0] ^ WHITEN_MASK;
         entry_lane_in.word_b = req_tdata[63:32] ^ WHITEN_MASK;
         entry_lane_in.sum    = total_sum;
      end else begin
         entry_lane_in.word_a = req_tdata[31:0];
         entry_lane_in.word_b = req_tdata[63:32];
         entry_lane_in.sum    = keys_ff.delta;
      end
   end

   assign entry_ready    = !entry_valid_ff || stage_ready[0];
   assign entry_valid_in = entry_ready ? req_tvalid : entry_valid_ff;
   assign req_tready     = entry_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else begin
         entry_valid_ff <= entry_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (entry_ready && req_tvalid) begin
         entry_lane_ff <= entry_lane_in;
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_lane[0]  = entry_lane_ff;

   // Half-round stages, alternating first and second half
   for (genvar g = 0; g < STAGES; g++) begin : g_round
      tvbc_round_stage #(
         .SECOND_HALF((g % 2) == 1)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .keys      (keys_ff),
         .in_valid  (stage_valid[g]),
         .in_ready  (stage_ready[g]),
         .in_lane   (stage_lane[g]),
         .out_valid (stage_valid[g+1]),
         .out_ready (stage_ready[g+1]),
         .out_lane  (stage_lane[g+1])
      );
   end

   // Output: whiten encrypted blocks after the last round
   assign stage_ready[STAGES] = rsp_tready;
   assign last_lane           = stage_lane[STAGES];
   assign rsp_tvalid          = stage_valid[STAGES];
   assign rsp_tdata = (last_lane.decrypt == REQ_DECRYPT)
                    ? {last_lane.word_b, last_lane.word_a}
                    : {last_lane.word_b ^ WHITEN_MASK, last_lane.word_a ^ WHITEN_MASK};

`ifndef SYNTHESIS
   // Back-pressure reaches the input only when every stage is full
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (entry_valid_ff && stage_valid[STAGES]))
      else $error("input stalled with an empty stage");

   // A ready sink must never block the input
   a_ready_path: assert property (@(posedge clock) disable iff (reset)
      rsp_tready |-> req_tready)
      else $error("ready lost along the pipeline");

   // Nothing leaves the pipeline straight after reset
   a_reset_empty: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> (!rsp_tvalid && !entry_valid_ff))
      else $error("pipeline not empty after reset");

   // An item taken at the input is in the entry stage next cycle
   a_entry_load: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> entry_valid_ff)
      else $error("accepted item missing from entry stage");
`endif

endmodule
